@@ hdl/jts_pkg.sv @@
// ----------------------------------------------------------------------------
// jts_pkg
// shared widths, token codes and record types of the json token scanner
// ----------------------------------------------------------------------------
package jts_pkg;

    localparam int LINE_BITS   = 20;
    localparam int OFFSET_BITS = 32;

    // at most three tokens come out of one text byte
    localparam int MAX_RES  = 3;
    localparam int CNT_BITS = $clog2(MAX_RES + 1);

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int FILL_BITS  = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [3:0] {
        K_LBRACE = 4'd0,
        K_RBRACE = 4'd1,
        K_LBRACK = 4'd2,
        K_RBRACK = 4'd3,
        K_COMMA  = 4'd4,
        K_COLON  = 4'd5,
        K_STRING = 4'd6,
        K_NUMBER = 4'd7,
        K_TRUE   = 4'd8,
        K_FALSE  = 4'd9,
        K_NULL   = 4'd10,
        K_EOF    = 4'd11,
        K_ERROR  = 4'd12
    } t_kind;

    typedef enum logic [1:0] {
        E_NONE            = 2'd0,
        E_UNTERM_STRING   = 2'd1,
        E_UNKNOWN_IDENT   = 2'd2,
        E_UNEXPECTED_CHAR = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        M_IDLE   = 3'd0,
        M_STR    = 3'd1,
        M_IDENT  = 3'd2,
        M_INT    = 3'd3,
        M_DOT    = 3'd4,
        M_FRAC   = 3'd5,
        M_HELD_E = 3'd6,
        M_EXP    = 3'd7
    } t_mode;

    typedef struct packed {
        t_kind                  kind;
        t_err                   err;
        logic [LINE_BITS-1:0]   line;
        logic [OFFSET_BITS-1:0] offset;
        logic [OFFSET_BITS-1:0] length;
        logic                   last;
    } t_token;

    // tokens made by one byte, in emission order, entries below count valid
    typedef struct packed {
        logic [CNT_BITS-1:0]      count;
        t_token [MAX_RES-1:0]     tok;
    } t_scan_out;

endpackage

@@ hdl/json_token_scanner.sv @@
// ----------------------------------------------------------------------------
// json_token_scanner
// streaming json tokenizer, one text byte per word in, one token per word out
// ----------------------------------------------------------------------------
// Text bytes go into an input register; the scanner step then works on that
// byte and drops every token it completes (none, one, two or three) into a
// four-entry result queue, which drives the output channel one token per
// word. A byte is taken every cycle as long as the queue holds at most one
// token, so plain text and single-token bytes stream at one byte per cycle;
// a byte that completes several tokens (a held '.' or 'e' flushing a number
// plus more) stalls the input until the queue is down to one token. With
// room in the queue, a byte's first token is offered on the output once the
// byte has passed the input register and been written to the queue. A zero
// byte ends the text with an eof token and resets to offset 0 on line 1.
// ----------------------------------------------------------------------------
module json_token_scanner (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // text in
    input  logic                               i_text_valid,
    output logic                               o_text_ready,
    input  logic [7:0]                         i_text_byte,
    // tokens out
    output logic                               o_token_valid,
    input  logic                               i_token_ready,
    output logic [3:0]                         o_token_kind,
    output logic [1:0]                         o_error_kind,
    output logic [jts_pkg::LINE_BITS-1:0]      o_line_number,
    output logic [jts_pkg::OFFSET_BITS-1:0]    o_token_offset,
    output logic [jts_pkg::OFFSET_BITS-1:0]    o_token_length,
    output logic                               o_last_of_run
);
    import jts_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    logic       space;
    logic       advance;
    t_scan_out  scan_res;
    t_token     head;

    // the held byte moves on when the queue can take a full burst
    assign advance      = r_in_valid && space;
    assign o_text_ready = !r_in_valid || space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text_valid && o_text_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_text_valid && o_text_ready) begin
            r_in_byte <= i_text_byte;
        end
    end

    // scanner step on the registered byte
    jts_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .o_res   (scan_res)
    );

    // result queue feeding the output channel
    jts_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (scan_res),
        .o_space (space),
        .o_valid (o_token_valid),
        .i_ready (i_token_ready),
        .o_tok   (head)
    );

    assign o_token_kind   = head.kind;
    assign o_error_kind   = head.err;
    assign o_line_number  = head.line;
    assign o_token_offset = head.offset;
    assign o_token_length = head.length;
    assign o_last_of_run  = head.last;

endmodule

@@ hdl/jts_scan.sv @@
// ----------------------------------------------------------------------------
// jts_scan
// scanner state and the per-byte step that yields up to three tokens
// ----------------------------------------------------------------------------
module jts_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    output jts_pkg::t_scan_out o_res
);
    import jts_pkg::*;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [2:0] WLEN_MAX = 3'd7;

    // candidate bits: 0 true, 1 false, 2 null
    function automatic logic [2:0] kw_match(input logic [2:0] wl, input logic [7:0] c);
        logic [2:0] m;
        case (wl)
            3'd0:    m = {c == "n", c == "f", c == "t"};
            3'd1:    m = {c == "u", c == "a", c == "r"};
            3'd2:    m = {c == "l", c == "l", c == "u"};
            3'd3:    m = {c == "l", c == "s", c == "e"};
            3'd4:    m = {1'b0, c == "e", 1'b0};
            default: m = 3'b000;
        endcase
        return m;
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alp(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == CH_UNDER);
    endfunction

    t_mode                  r_mode,  n_mode;
    logic [LINE_BITS-1:0]   r_line,  n_line;
    logic [OFFSET_BITS-1:0] r_pos,   n_pos;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [2:0]             r_wlen,  n_wlen;
    logic [2:0]             r_cand,  n_cand;

    logic                   a_v, b_v, c_v, run_idle, eof;
    t_token                 a_tok, b_tok, c_tok;
    logic [7:0]             ch;
    logic [OFFSET_BITS-1:0] prev, span_pos, span_prev;
    logic [CNT_BITS-1:0]    cnt;
    t_kind                  word_kind;
    t_err                   word_err;

    function automatic t_token mk_tok(input t_kind k, input t_err e,
                                      input logic [LINE_BITS-1:0] ln,
                                      input logic [OFFSET_BITS-1:0] off,
                                      input logic [OFFSET_BITS-1:0] len);
        t_token t;
        t.kind   = k;
        t.err    = e;
        t.line   = ln;
        t.offset = off;
        t.length = len;
        t.last   = 1'b0;
        return t;
    endfunction

    assign ch        = i_byte;
    assign prev      = r_pos - OFFSET_BITS'(1);
    assign span_pos  = r_pos - r_start;
    assign span_prev = prev - r_start;

    // keyword decision for a finished word
    always_comb begin
        word_err = E_NONE;
        if ((r_wlen == 3'd4) && r_cand[0]) begin
            word_kind = K_TRUE;
        end else if ((r_wlen == 3'd5) && r_cand[1]) begin
            word_kind = K_FALSE;
        end else if ((r_wlen == 3'd4) && r_cand[2]) begin
            word_kind = K_NULL;
        end else begin
            word_kind = K_ERROR;
            word_err  = E_UNKNOWN_IDENT;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_line   = r_line;
        n_pos    = r_pos + OFFSET_BITS'(1);
        n_start  = r_start;
        n_wlen   = r_wlen;
        n_cand   = r_cand;
        a_v      = 1'b0;
        b_v      = 1'b0;
        c_v      = 1'b0;
        a_tok    = mk_tok(K_NUMBER, E_NONE, r_line, r_start, span_pos);
        b_tok    = mk_tok(K_ERROR, E_UNEXPECTED_CHAR, r_line, prev, OFFSET_BITS'(1));
        c_tok    = mk_tok(K_ERROR, E_UNEXPECTED_CHAR, r_line, r_pos, OFFSET_BITS'(1));
        run_idle = 1'b0;
        eof      = 1'b0;

        // close or extend the open token
        case (r_mode)
            M_IDLE: begin
                run_idle = 1'b1;
            end
            M_STR: begin
                if (ch == CH_QUOTE) begin
                    a_v    = 1'b1;
                    a_tok  = mk_tok(K_STRING, E_NONE, r_line, r_start,
                                    span_pos + OFFSET_BITS'(1));
                    n_mode = M_IDLE;
                end else if (ch == CH_NUL) begin
                    a_v      = 1'b1;
                    a_tok    = mk_tok(K_ERROR, E_UNTERM_STRING, r_line, r_start, span_pos);
                    run_idle = 1'b1;
                end
            end
            M_IDENT: begin
                if (is_alp(ch) || is_dig(ch)) begin
                    n_cand = r_cand & kw_match(r_wlen, ch);
                    if (r_wlen != WLEN_MAX) begin
                        n_wlen = r_wlen + 3'd1;
                    end
                end else begin
                    a_v      = 1'b1;
                    a_tok    = mk_tok(word_kind, word_err, r_line, r_start, span_pos);
                    n_wlen   = 3'd0;
                    n_cand   = 3'd0;
                    run_idle = 1'b1;
                end
            end
            M_INT: begin
                if (ch == CH_DOT) begin
                    n_mode = M_DOT;
                end else if (ch == CH_E) begin
                    n_mode = M_HELD_E;
                end else if (!is_dig(ch)) begin
                    a_v      = 1'b1;
                    run_idle = 1'b1;
                end
            end
            M_DOT: begin
                if (is_dig(ch)) begin
                    n_mode = M_FRAC;
                end else begin
                    // number ends before the held dot, the dot is an error
                    a_v      = 1'b1;
                    a_tok    = mk_tok(K_NUMBER, E_NONE, r_line, r_start, span_prev);
                    b_v      = 1'b1;
                    run_idle = 1'b1;
                end
            end
            M_FRAC: begin
                if (ch == CH_E) begin
                    n_mode = M_HELD_E;
                end else if (!is_dig(ch)) begin
                    a_v      = 1'b1;
                    run_idle = 1'b1;
                end
            end
            M_HELD_E: begin
                if (is_dig(ch)) begin
                    n_mode = M_EXP;
                end else begin
                    // held e becomes a word that can never be a keyword
                    a_v   = 1'b1;
                    a_tok = mk_tok(K_NUMBER, E_NONE, r_line, r_start, span_prev);
                    if (is_alp(ch)) begin
                        n_mode  = M_IDENT;
                        n_start = prev;
                        n_wlen  = 3'd2;
                        n_cand  = 3'd0;
                    end else begin
                        b_v      = 1'b1;
                        b_tok    = mk_tok(K_ERROR, E_UNKNOWN_IDENT, r_line, prev,
                                          OFFSET_BITS'(1));
                        run_idle = 1'b1;
                    end
                end
            end
            M_EXP: begin
                if (!is_dig(ch)) begin
                    a_v      = 1'b1;
                    run_idle = 1'b1;
                end
            end
            default: begin
                run_idle = 1'b1;
            end
        endcase

        // scan the byte between tokens
        if (run_idle) begin
            n_mode = M_IDLE;
            case (ch)
                CH_NUL: begin
                    c_v   = 1'b1;
                    c_tok = mk_tok(K_EOF, E_NONE, r_line, r_pos, '0);
                    eof   = 1'b1;
                end
                CH_SPACE, CH_TAB, CH_CR: begin
                end
                CH_LF: begin
                    if (r_line != '1) begin
                        n_line = r_line + LINE_BITS'(1);
                    end
                end
                CH_LBRACE: begin
                    c_v   = 1'b1;
                    c_tok = mk_tok(K_LBRACE, E_NONE, r_line, r_pos, OFFSET_BITS'(1));
                end
                CH_RBRACE: begin
                    c_v   = 1'b1;
                    c_tok = mk_tok(K_RBRACE, E_NONE, r_line, r_pos, OFFSET_BITS'(1));
                end
                CH_LBRACK: begin
                    c_v   = 1'b1;
                    c_tok = mk_tok(K_LBRACK, E_NONE, r_line, r_pos, OFFSET_BITS'(1));
                end
                CH_RBRACK: begin
                    c_v   = 1'b1;
                    c_tok = mk_tok(K_RBRACK, E_NONE, r_line, r_pos, OFFSET_BITS'(1));
                end
                CH_COMMA: begin
                    c_v   = 1'b1;
                    c_tok = mk_tok(K_COMMA, E_NONE, r_line, r_pos, OFFSET_BITS'(1));
                end
                CH_COLON: begin
                    c_v   = 1'b1;
                    c_tok = mk_tok(K_COLON, E_NONE, r_line, r_pos, OFFSET_BITS'(1));
                end
                CH_QUOTE: begin
                    n_mode  = M_STR;
                    n_start = r_pos;
                end
                default: begin
                    if (is_dig(ch)) begin
                        n_mode  = M_INT;
                        n_start = r_pos;
                    end else if (is_alp(ch)) begin
                        n_mode  = M_IDENT;
                        n_start = r_pos;
                        n_wlen  = 3'd1;
                        n_cand  = {ch == "n", ch == "f", ch == "t"};
                    end else begin
                        c_v = 1'b1;
                    end
                end
            endcase
        end

        // end of text puts everything back to reset values
        if (eof) begin
            n_mode  = M_IDLE;
            n_line  = LINE_BITS'(1);
            n_pos   = '0;
            n_start = '0;
            n_wlen  = 3'd0;
            n_cand  = 3'd0;
        end
    end

    // pack in order: the second slot is only used with the first one
    always_comb begin
        if (a_v) begin
            cnt = CNT_BITS'(1) + CNT_BITS'(b_v) + CNT_BITS'(c_v);
        end else begin
            cnt = CNT_BITS'(c_v);
        end
        o_res.count  = i_step ? cnt : '0;
        o_res.tok[0] = a_v ? a_tok : c_tok;
        o_res.tok[1] = b_v ? b_tok : c_tok;
        o_res.tok[2] = c_tok;
        for (int i = 0; i < MAX_RES; i++) begin
            o_res.tok[i].last = (CNT_BITS'(i) + CNT_BITS'(1) == cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_line  <= LINE_BITS'(1);
            r_pos   <= '0;
            r_start <= '0;
            r_wlen  <= 3'd0;
            r_cand  <= 3'd0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_wlen  <= n_wlen;
            r_cand  <= n_cand;
        end
    end

endmodule

@@ hdl/jts_fifo.sv @@
// ----------------------------------------------------------------------------
// jts_fifo
// small result queue taking up to three tokens a cycle, giving one
// ----------------------------------------------------------------------------
module jts_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jts_pkg::t_scan_out i_push,
    output logic               o_space,
    output logic               o_valid,
    input  logic               i_ready,
    output jts_pkg::t_token    o_tok
);
    import jts_pkg::*;

    t_token               r_mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0]  r_wr;
    logic [PTR_BITS-1:0]  r_rd;
    logic [FILL_BITS-1:0] r_fill;
    logic                 pop;

    assign o_valid = (r_fill != '0);
    assign pop     = o_valid && i_ready;
    assign o_tok   = r_mem[r_rd];
    // room for a full burst of three
    assign o_space = (r_fill <= FILL_BITS'(FIFO_DEPTH - MAX_RES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= r_wr + PTR_BITS'(i_push.count);
            r_rd   <= r_rd + PTR_BITS'(pop);
            r_fill <= r_fill + FILL_BITS'(i_push.count) - FILL_BITS'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (CNT_BITS'(i) < i_push.count) begin
                r_mem[r_wr + PTR_BITS'(i)] <= i_push.tok[i];
            end
        end
    end

endmodule

@@ verif/json_token_scanner_checker.sv @@
// ----------------------------------------------------------------------------
// json_token_scanner_checker
// predicts the tokens of every accepted text byte and compares each token
// word, field by field, with the oldest prediction still due
// ----------------------------------------------------------------------------
module json_token_scanner_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_text_valid,
    input  logic                            i_text_ready,
    input  logic [7:0]                      i_text_byte,
    input  logic                            i_token_valid,
    input  logic                            i_token_ready,
    input  logic [3:0]                      i_token_kind,
    input  logic [1:0]                      i_error_kind,
    input  logic [jts_pkg::LINE_BITS-1:0]   i_line_number,
    input  logic [jts_pkg::OFFSET_BITS-1:0] i_token_offset,
    input  logic [jts_pkg::OFFSET_BITS-1:0] i_token_length,
    input  logic                            i_last_of_run,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import jts_pkg::*;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;

    localparam logic [39:0] WORD_TRUE  = "true";
    localparam logic [39:0] WORD_FALSE = "false";
    localparam logic [39:0] WORD_NULL  = "null";

    localparam logic [2:0] CAND_TRUE  = 3'b001;
    localparam logic [2:0] CAND_FALSE = 3'b010;
    localparam logic [2:0] CAND_NULL  = 3'b100;

    // scanner copy
    t_mode                  scan_mode  = M_IDLE;
    logic [LINE_BITS-1:0]   line_no    = LINE_BITS'(1);
    logic [OFFSET_BITS-1:0] byte_pos   = '0;
    logic [OFFSET_BITS-1:0] tok_start  = '0;
    logic [2:0]             word_len   = '0;
    logic [2:0]             kw_live    = '0;
    bit                     hit_eof;

    t_token step_tok [MAX_RES];
    int     n_step;
    t_token tokens_due [$];
    int     fail_cnt = 0;

    function automatic bit is_num_byte(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_word_byte(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    // true when character i of an n-character keyword is c
    function automatic bit char_fits(logic [39:0] w, int n, int i, logic [7:0] c);
        if (i >= n)
            return 1'b0;
        return w[8*(n-1-i) +: 8] == c;
    endfunction

    function automatic void clear_scan();
        scan_mode = M_IDLE;
        line_no   = LINE_BITS'(1);
        byte_pos  = '0;
        tok_start = '0;
        word_len  = '0;
        kw_live   = '0;
    endfunction

    function automatic void note_token(t_kind kind, t_err err,
                                       logic [OFFSET_BITS-1:0] offset,
                                       logic [OFFSET_BITS-1:0] length);
        t_token tok;
        if (n_step < MAX_RES) begin
            tok.kind   = kind;
            tok.err    = err;
            tok.line   = line_no;
            tok.offset = offset;
            tok.length = length;
            tok.last   = 1'b0;
            step_tok[n_step] = tok;
            n_step++;
        end
    endfunction

    function automatic void begin_word(logic [7:0] c, logic [OFFSET_BITS-1:0] pos);
        scan_mode = M_IDENT;
        tok_start = pos;
        word_len  = 3'd1;
        kw_live   = {c == "n", c == "f", c == "t"};
    endfunction

    function automatic void scan_between(logic [7:0] c, logic [OFFSET_BITS-1:0] pos);
        scan_mode = M_IDLE;
        case (c)
            CH_NUL: begin
                note_token(K_EOF, E_NONE, pos, '0);
                hit_eof = 1'b1;
            end
            " ", CH_TAB, CH_CR: ;
            CH_LF: if (line_no != {LINE_BITS{1'b1}}) line_no++;
            "{": note_token(K_LBRACE, E_NONE, pos, 1);
            "}": note_token(K_RBRACE, E_NONE, pos, 1);
            "[": note_token(K_LBRACK, E_NONE, pos, 1);
            "]": note_token(K_RBRACK, E_NONE, pos, 1);
            ",": note_token(K_COMMA, E_NONE, pos, 1);
            ":": note_token(K_COLON, E_NONE, pos, 1);
            "\"": begin
                scan_mode = M_STR;
                tok_start = pos;
            end
            default: begin
                if (is_num_byte(c)) begin
                    scan_mode = M_INT;
                    tok_start = pos;
                end else if (is_word_byte(c)) begin
                    begin_word(c, pos);
                end else begin
                    note_token(K_ERROR, E_UNEXPECTED_CHAR, pos, 1);
                end
            end
        endcase
    endfunction

    function automatic void scan_word(logic [7:0] c, logic [OFFSET_BITS-1:0] pos);
        logic [OFFSET_BITS-1:0] len;
        len = pos - tok_start;
        if (is_word_byte(c) || is_num_byte(c)) begin
            if (!char_fits(WORD_TRUE, 4, word_len, c))  kw_live &= ~CAND_TRUE;
            if (!char_fits(WORD_FALSE, 5, word_len, c)) kw_live &= ~CAND_FALSE;
            if (!char_fits(WORD_NULL, 4, word_len, c))  kw_live &= ~CAND_NULL;
            if (word_len < 3'd7)
                word_len++;
            return;
        end
        if (word_len == 3'd4 && (kw_live & CAND_TRUE) != 0)
            note_token(K_TRUE, E_NONE, tok_start, len);
        else if (word_len == 3'd5 && (kw_live & CAND_FALSE) != 0)
            note_token(K_FALSE, E_NONE, tok_start, len);
        else if (word_len == 3'd4 && (kw_live & CAND_NULL) != 0)
            note_token(K_NULL, E_NONE, tok_start, len);
        else
            note_token(K_ERROR, E_UNKNOWN_IDENT, tok_start, len);
        word_len = '0;
        kw_live  = '0;
        scan_between(c, pos);
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        logic [OFFSET_BITS-1:0] pos;
        logic [OFFSET_BITS-1:0] prev;
        t_token tok;
        pos     = byte_pos;
        prev    = pos - 1;
        n_step  = 0;
        hit_eof = 1'b0;
        case (scan_mode)
            M_STR: begin
                if (c == "\"") begin
                    note_token(K_STRING, E_NONE, tok_start, pos - tok_start + 1);
                    scan_mode = M_IDLE;
                end else if (c == CH_NUL) begin
                    note_token(K_ERROR, E_UNTERM_STRING, tok_start, pos - tok_start);
                    scan_between(c, pos);
                end
            end
            M_IDENT: scan_word(c, pos);
            M_INT, M_FRAC: begin
                if (is_num_byte(c)) begin
                end else if (c == "." && scan_mode == M_INT) begin
                    scan_mode = M_DOT;
                end else if (c == "e") begin
                    scan_mode = M_HELD_E;
                end else begin
                    note_token(K_NUMBER, E_NONE, tok_start, pos - tok_start);
                    scan_between(c, pos);
                end
            end
            M_DOT: begin
                if (is_num_byte(c)) begin
                    scan_mode = M_FRAC;
                end else begin
                    // dot without digit is a stray character of its own
                    note_token(K_NUMBER, E_NONE, tok_start, prev - tok_start);
                    note_token(K_ERROR, E_UNEXPECTED_CHAR, prev, 1);
                    scan_between(c, pos);
                end
            end
            M_HELD_E: begin
                if (is_num_byte(c)) begin
                    scan_mode = M_EXP;
                end else begin
                    // the held e turns into a word that this byte may extend
                    note_token(K_NUMBER, E_NONE, tok_start, prev - tok_start);
                    begin_word("e", prev);
                    scan_word(c, pos);
                end
            end
            M_EXP: begin
                if (!is_num_byte(c)) begin
                    note_token(K_NUMBER, E_NONE, tok_start, pos - tok_start);
                    scan_between(c, pos);
                end
            end
            default: scan_between(c, pos);
        endcase
        if (hit_eof)
            clear_scan();
        else
            byte_pos = pos + 1;
        for (int i = 0; i < n_step; i++) begin
            tok      = step_tok[i];
            tok.last = (i == n_step - 1);
            tokens_due.push_back(tok);
        end
    endfunction

    task automatic check_token();
        t_token want;
        if (tokens_due.size() == 0) begin
            $error("token word with nothing due: kind %0d offset %0d",
                   i_token_kind, i_token_offset);
            fail_cnt++;
            return;
        end
        want = tokens_due.pop_front();
        if (i_token_kind !== want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, i_token_kind);
            fail_cnt++;
        end
        if (i_error_kind !== want.err) begin
            $error("error_kind: expected %0d, got %0d", want.err, i_error_kind);
            fail_cnt++;
        end
        if (i_line_number !== want.line) begin
            $error("line_number: expected %0d, got %0d", want.line, i_line_number);
            fail_cnt++;
        end
        if (i_token_offset !== want.offset) begin
            $error("token_offset: expected %0d, got %0d", want.offset, i_token_offset);
            fail_cnt++;
        end
        if (i_token_length !== want.length) begin
            $error("token_length: expected %0d, got %0d", want.length, i_token_length);
            fail_cnt++;
        end
        if (i_last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, i_last_of_run);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scan();
            tokens_due.delete();
        end else begin
            if (i_token_valid && i_token_ready)
                check_token();
            if (i_text_valid && i_text_ready)
                scan_byte(i_text_byte);
        end
        o_fail_count <= fail_cnt;
        o_pending    <= tokens_due.size();
    end

endmodule

@@ verif/json_token_scanner_tb.sv @@
// ----------------------------------------------------------------------------
// json_token_scanner_tb
// drives text bytes into the scanner with random gaps and back-pressure on
// the token side; a checker beside the block predicts and compares tokens
// ----------------------------------------------------------------------------
module json_token_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = "\"";
    localparam logic [7:0] CH_BSL   = 8'h5c;

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             i_text_valid  = 1'b0;
    logic                             o_text_ready;
    logic [7:0]                       i_text_byte   = '0;
    logic                             o_token_valid;
    logic                             i_token_ready = 1'b0;
    logic [3:0]                       o_token_kind;
    logic [1:0]                       o_error_kind;
    logic [jts_pkg::LINE_BITS-1:0]    o_line_number;
    logic [jts_pkg::OFFSET_BITS-1:0]  o_token_offset;
    logic [jts_pkg::OFFSET_BITS-1:0]  o_token_length;
    logic                             o_last_of_run;

    int fail_count;
    int pending;

    // chance in a hundred that a side sits out a cycle
    int tx_idle_pct = 35;
    int rx_idle_pct = 35;

    int         n_sent = 0;
    logic [7:0] text_q [$];

    always #4 i_clk = ~i_clk;

    json_token_scanner dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_text_valid   (i_text_valid),
        .o_text_ready   (o_text_ready),
        .i_text_byte    (i_text_byte),
        .o_token_valid  (o_token_valid),
        .i_token_ready  (i_token_ready),
        .o_token_kind   (o_token_kind),
        .o_error_kind   (o_error_kind),
        .o_line_number  (o_line_number),
        .o_token_offset (o_token_offset),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

    json_token_scanner_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_text_valid   (i_text_valid),
        .i_text_ready   (o_text_ready),
        .i_text_byte    (i_text_byte),
        .i_token_valid  (o_token_valid),
        .i_token_ready  (i_token_ready),
        .i_token_kind   (o_token_kind),
        .i_error_kind   (o_error_kind),
        .i_line_number  (o_line_number),
        .i_token_offset (o_token_offset),
        .i_token_length (o_token_length),
        .i_last_of_run  (o_last_of_run),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // token side back-pressure, re-drawn every cycle
    always @(negedge i_clk) begin
        i_token_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic queue_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic queue_digits(int n);
        repeat (n) text_q.push_back(pick("0123456789"));
    endtask

    // one text word; called and left at a falling edge. valid only drops
    // when a gap is drawn, so it is never lowered and raised in one step
    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_text_valid <= 1'b0;
            i_text_byte  <= 8'($urandom_range(0, 255));
            @(negedge i_clk);
        end
        i_text_valid <= 1'b1;
        i_text_byte  <= b;
        do @(posedge i_clk); while (!o_text_ready);
        @(negedge i_clk);
        n_sent++;
    endtask

    task automatic send_queued();
        while (text_q.size() > 0)
            send_byte(text_q.pop_front());
    endtask

    // hold the text side off until every predicted token has been taken
    task automatic wait_drained();
        i_text_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // mostly well-formed json pieces with random content, plus some noise,
    // broken numbers, stray bytes and end-of-text bytes landing anywhere
    task automatic queue_fragment();
        int         n;
        logic [7:0] b;
        bit         value_made;
        value_made = 1'b0;
        case ($urandom_range(0, 13))
            0, 1: text_q.push_back(pick("{}[],:"));
            2:    text_q.push_back(pick(" \t\r\n"));
            3, 4: begin
                // string body may hold newlines and backslashes
                text_q.push_back(CH_QUOTE);
                n = $urandom_range(0, 6);
                repeat (n) begin
                    b = 8'($urandom_range(1, 255));
                    text_q.push_back(b == CH_QUOTE ? CH_BSL : b);
                end
                text_q.push_back(CH_QUOTE);
                value_made = 1'b1;
            end
            5, 6: begin
                queue_digits($urandom_range(1, 3));
                if ($urandom_range(0, 1)) begin
                    text_q.push_back(".");
                    queue_digits($urandom_range(1, 2));
                end
                if ($urandom_range(0, 1)) begin
                    text_q.push_back("e");
                    queue_digits($urandom_range(1, 2));
                end
                value_made = 1'b1;
            end
            7: begin
                // number left hanging on a dot or an e, then anything
                queue_digits($urandom_range(1, 2));
                if ($urandom_range(0, 1)) begin
                    text_q.push_back(".");
                    queue_digits(1);
                end
                text_q.push_back(pick(".e"));
                if ($urandom_range(0, 1))
                    text_q.push_back(8'($urandom_range(0, 255)));
                else
                    text_q.push_back(pick(".e_x\" ,9"));
            end
            8, 9: begin
                case ($urandom_range(0, 2))
                    0: queue_text("true");
                    1: queue_text("false");
                    default: queue_text("null");
                endcase
                value_made = 1'b1;
            end
            10: begin
                // near-keywords and long words
                n = $urandom_range(1, 9);
                text_q.push_back(pick("tfnex_AZ"));
                repeat (n - 1) text_q.push_back(pick("truefalsn_09Z"));
                value_made = 1'b1;
            end
            11: text_q.push_back(8'($urandom_range(1, 255)));
            12: text_q.push_back(CH_NUL);
            default: begin
                // string cut short by the end of text
                text_q.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 4)) begin
                    b = 8'($urandom_range(1, 255));
                    text_q.push_back(b == CH_QUOTE ? CH_BSL : b);
                end
                text_q.push_back(CH_NUL);
            end
        endcase
        if (value_made && $urandom_range(0, 3) != 0)
            text_q.push_back(pick(" ,:]}\n\t"));
    endtask

    task automatic random_text(int count);
        int stop_at;
        stop_at = n_sent + count;
        while (n_sent < stop_at) begin
            queue_fragment();
            send_queued();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: all punctuation, backslash in a string, full number,
        // dot and e left hanging, second dot, keywords, newline ending a
        // token, long word, stray byte, open string at end of text
        queue_text("{\"\\\":[1.5e9,7.,3e]}\n");
        queue_text("1.2.null\nfalsehood true#\"x");
        text_q.push_back(CH_NUL);
        send_queued();
        wait_drained();

        random_text(110);
        wait_drained();

        // no idling on either side for a stretch
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_text(90);

        tx_idle_pct = 35;
        rx_idle_pct = 35;
        random_text(110);
        text_q.push_back(CH_NUL);
        send_queued();

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("json_token_scanner_tb OK");
        else
            $display("json_token_scanner_tb NOT OK");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("json_token_scanner_tb NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
hdl/jts_pkg.sv
hdl/jts_scan.sv
hdl/jts_fifo.sv
hdl/json_token_scanner.sv
verif/json_token_scanner_checker.sv
verif/json_token_scanner_tb.sv
